@@ design/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg: shared definitions for the LED matrix row scan serializer
// Matrix geometry, scan frame length, request kinds and the frame store
// write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int ROW_W       = $clog2(MATRIX_SIZE);
    localparam int HALF_ROWS   = MATRIX_SIZE / 2;
    localparam int SCAN_BITS   = 2 * MATRIX_SIZE;
    localparam int CNT_W       = $clog2(SCAN_BITS);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } op_t;

    typedef struct packed {
        logic                   en;
        logic [ROW_W-1:0]       row;
        logic [MATRIX_SIZE-1:0] data;
    } fs_write_t;

endpackage

`default_nettype wire

@@ design/led_matrix_row_scan_serializer.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scan_serializer: 8x8 LED matrix row scan serializer
// Stores frame rows and shifts out one scan row per scan request as a
// sixteen-bit serial stream for chained shift registers.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: operation; tdata: row_index, row_data
//  m_axis   | out       | tdata: data_bit; tlast: latch (sixteenth bit)
//
//  A write request updates the frame store; it gives no output. A scan
//  request loads a 16-bit shift register and then sends one bit per
//  accepted output beat. The next request is taken in the cycle the last
//  bit leaves. A stall on m_axis holds the current bit. Reset clears the
//  frame store, the scan row and the shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_row_scan_serializer
    import lmrs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [2:0] row_index, [10:3] row_data
    input  wire logic                   s_axis_tuser,   // [0] operation
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] data_bit
    output logic                        m_axis_tlast
);

    logic                 valid_reg, valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SCAN_BITS-1:0] shift_reg, shift_next;
    logic [ROW_W-1:0]     row_reg, row_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 last_bit;
    logic                 is_scan;
    fs_write_t            fs_wr;
    logic [SCAN_BITS-1:0] scan_word;

    assign last_bit = (cnt_reg == CNT_W'(SCAN_BITS - 1));
    assign out_fire = valid_reg && m_axis_tready;

    // Take a new request when idle, or as the final bit of a row leaves.
    assign s_axis_tready = !valid_reg || (m_axis_tready && last_bit);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_scan       = (op_t'(s_axis_tuser) == OP_SCAN);

    assign fs_wr.en   = in_fire && !is_scan;
    assign fs_wr.row  = s_axis_tdata[ROW_W-1:0];
    assign fs_wr.data = s_axis_tdata[ROW_W +: MATRIX_SIZE];

    lmrs_frame_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (fs_wr),
        .scan_row  (row_reg),
        .scan_word (scan_word)
    );

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        row_next   = row_reg;
        if (out_fire)
        begin
            // Advance to the next serial bit, drop valid after the last one.
            shift_next = {shift_reg[SCAN_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (last_bit)
            begin
                valid_next = 1'b0;
            end
        end
        if (in_fire && is_scan)
        begin
            // Load the row word and step the scan row, wrapping at the end.
            valid_next = 1'b1;
            cnt_next   = '0;
            shift_next = scan_word;
            row_next   = row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            row_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            shift_reg <= shift_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, shift_reg[SCAN_BITS-1]};
    assign m_axis_tlast  = last_bit;

endmodule

`default_nettype wire

@@ design/lmrs_frame_store.sv @@
// ----------------------------------------------------------------------------
// lmrs_frame_store: frame row storage and scan word assembly
// Holds the eight frame rows and builds the sixteen-bit scan word for a
// given scan row, first serial bit in the top bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_frame_store
    import lmrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fs_write_t            wr,
    input  wire logic [ROW_W-1:0]     scan_row,
    output logic      [SCAN_BITS-1:0] scan_word
);

    logic [MATRIX_SIZE-1:0] rows_reg [MATRIX_SIZE];
    logic [MATRIX_SIZE-1:0] pix;
    logic [MATRIX_SIZE-1:0] sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_SIZE; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            rows_reg[wr.row] <= wr.data;
        end
    end

    // Column (7 - r) of every row, plus active-low position selects.
    always_comb
    begin
        for (int j = 0; j < MATRIX_SIZE; j++)
        begin
            pix[j] = rows_reg[j][~scan_row];
            sel[j] = (scan_row != ROW_W'(j));
        end
    end

    always_comb
    begin
        for (int i = 0; i < HALF_ROWS; i++)
        begin
            scan_word[SCAN_BITS-1-i]               = pix[MATRIX_SIZE-1-i];
            scan_word[SCAN_BITS-1-HALF_ROWS-i]     = sel[HALF_ROWS-1-i];
            scan_word[SCAN_BITS-1-2*HALF_ROWS-i]   = pix[i];
            scan_word[SCAN_BITS-1-3*HALF_ROWS-i]   = sel[HALF_ROWS+i];
        end
    end

endmodule

`default_nettype wire
